// ----- rtl/core/sjis_hfw_pkg.sv -----
// ----------------------------------------------------------------------------
// SJIS half/full width converter package
// Code tables, byte-class helpers and the result struct shared by the unit.
// ----------------------------------------------------------------------------
package sjis_hfw_pkg;

  typedef enum logic [0:0] {
    CFG_DIRECTION = 1'b0,
    CFG_BYPASS    = 1'b1
  } cfg_idx_e;

  localparam logic [7:0] LowFirst = 8'h20;
  localparam logic [7:0] LowLast  = 8'h7E;
  localparam logic [7:0] UpFirst  = 8'hA1;
  localparam logic [7:0] UpLast   = 8'hDF;

  // Converted item: up to two bytes
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } res_t;

  function automatic logic [15:0] lower_code(input logic [6:0] i);
    logic [15:0] c;
    begin
      case (i)
        7'd0: c = 16'h8140; 7'd1: c = 16'h8149; 7'd2: c = 16'hEEFC; 7'd3: c = 16'h8194;
        7'd4: c = 16'h8190; 7'd5: c = 16'h8193; 7'd6: c = 16'h8195; 7'd7: c = 16'hEEFB;
        7'd8: c = 16'h8169; 7'd9: c = 16'h816A; 7'd10: c = 16'h8196; 7'd11: c = 16'h817B;
        7'd12: c = 16'h8143; 7'd13: c = 16'h817C; 7'd14: c = 16'h8144; 7'd15: c = 16'h815E;
        7'd16: c = 16'h824F; 7'd17: c = 16'h8250; 7'd18: c = 16'h8251; 7'd19: c = 16'h8252;
        7'd20: c = 16'h8253; 7'd21: c = 16'h8254; 7'd22: c = 16'h8255; 7'd23: c = 16'h8256;
        7'd24: c = 16'h8257; 7'd25: c = 16'h8258; 7'd26: c = 16'h8146; 7'd27: c = 16'h8147;
        7'd28: c = 16'h8183; 7'd29: c = 16'h8181; 7'd30: c = 16'h8184; 7'd31: c = 16'h8148;
        7'd32: c = 16'h8197; 7'd33: c = 16'h8260; 7'd34: c = 16'h8261; 7'd35: c = 16'h8262;
        7'd36: c = 16'h8263; 7'd37: c = 16'h8264; 7'd38: c = 16'h8265; 7'd39: c = 16'h8266;
        7'd40: c = 16'h8267; 7'd41: c = 16'h8268; 7'd42: c = 16'h8269; 7'd43: c = 16'h826A;
        7'd44: c = 16'h826B; 7'd45: c = 16'h826C; 7'd46: c = 16'h826D; 7'd47: c = 16'h826E;
        7'd48: c = 16'h826F; 7'd49: c = 16'h8270; 7'd50: c = 16'h8271; 7'd51: c = 16'h8272;
        7'd52: c = 16'h8273; 7'd53: c = 16'h8274; 7'd54: c = 16'h8275; 7'd55: c = 16'h8276;
        7'd56: c = 16'h8277; 7'd57: c = 16'h8278; 7'd58: c = 16'h8279; 7'd59: c = 16'h816D;
        7'd60: c = 16'h815F; 7'd61: c = 16'h816E; 7'd62: c = 16'h814F; 7'd63: c = 16'h8151;
        7'd64: c = 16'h814D; 7'd65: c = 16'h8281; 7'd66: c = 16'h8282; 7'd67: c = 16'h8283;
        7'd68: c = 16'h8284; 7'd69: c = 16'h8285; 7'd70: c = 16'h8286; 7'd71: c = 16'h8287;
        7'd72: c = 16'h8288; 7'd73: c = 16'h8289; 7'd74: c = 16'h828A; 7'd75: c = 16'h828B;
        7'd76: c = 16'h828C; 7'd77: c = 16'h828D; 7'd78: c = 16'h828E; 7'd79: c = 16'h828F;
        7'd80: c = 16'h8290; 7'd81: c = 16'h8291; 7'd82: c = 16'h8292; 7'd83: c = 16'h8293;
        7'd84: c = 16'h8294; 7'd85: c = 16'h8295; 7'd86: c = 16'h8296; 7'd87: c = 16'h8297;
        7'd88: c = 16'h8298; 7'd89: c = 16'h8299; 7'd90: c = 16'h829A; 7'd91: c = 16'h816F;
        7'd92: c = 16'h8162; 7'd93: c = 16'h8170; 7'd94: c = 16'h8160;
        default: c = 16'h0000;
      endcase
      return c;
    end
  endfunction

  function automatic logic [15:0] upper_code(input logic [5:0] i);
    logic [15:0] c;
    begin
      case (i)
        6'd0: c = 16'h8142; 6'd1: c = 16'h8175; 6'd2: c = 16'h8176; 6'd3: c = 16'h8141;
        6'd4: c = 16'h8145; 6'd5: c = 16'h8392; 6'd6: c = 16'h8340; 6'd7: c = 16'h8342;
        6'd8: c = 16'h8344; 6'd9: c = 16'h8346; 6'd10: c = 16'h8348; 6'd11: c = 16'h8383;
        6'd12: c = 16'h8385; 6'd13: c = 16'h8387; 6'd14: c = 16'h8362; 6'd15: c = 16'h815B;
        6'd16: c = 16'h8341; 6'd17: c = 16'h8343; 6'd18: c = 16'h8345; 6'd19: c = 16'h8347;
        6'd20: c = 16'h8349; 6'd21: c = 16'h834A; 6'd22: c = 16'h834C; 6'd23: c = 16'h834E;
        6'd24: c = 16'h8350; 6'd25: c = 16'h8352; 6'd26: c = 16'h8354; 6'd27: c = 16'h8356;
        6'd28: c = 16'h8358; 6'd29: c = 16'h835A; 6'd30: c = 16'h835C; 6'd31: c = 16'h835E;
        6'd32: c = 16'h8360; 6'd33: c = 16'h8363; 6'd34: c = 16'h8365; 6'd35: c = 16'h8367;
        6'd36: c = 16'h8369; 6'd37: c = 16'h836A; 6'd38: c = 16'h836B; 6'd39: c = 16'h836C;
        6'd40: c = 16'h836D; 6'd41: c = 16'h836E; 6'd42: c = 16'h8371; 6'd43: c = 16'h8374;
        6'd44: c = 16'h8377; 6'd45: c = 16'h837A; 6'd46: c = 16'h837D; 6'd47: c = 16'h837E;
        6'd48: c = 16'h8380; 6'd49: c = 16'h8381; 6'd50: c = 16'h8382; 6'd51: c = 16'h8384;
        6'd52: c = 16'h8386; 6'd53: c = 16'h8388; 6'd54: c = 16'h8389; 6'd55: c = 16'h838A;
        6'd56: c = 16'h838B; 6'd57: c = 16'h838C; 6'd58: c = 16'h838D; 6'd59: c = 16'h838F;
        6'd60: c = 16'h8393; 6'd61: c = 16'h814A; 6'd62: c = 16'h814B;
        default: c = 16'h0000;
      endcase
      return c;
    end
  endfunction

  function automatic logic is_lead(input logic [7:0] b);
    return ((b >= 8'h81) && (b <= 8'h9F)) || ((b >= 8'hE0) && (b <= 8'hFC));
  endfunction

endpackage

// ----- rtl/core/sjis_half_full_width_converter_unit.sv -----
// ----------------------------------------------------------------------------
// SJIS half/full width converter unit
// Byte-stream converter between halfwidth and fullwidth Shift-JIS codes.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  input   | in_valid_i, in_stall_o, in_byte_i, end_of_string_i | in
//  output  | out_valid_o, out_stall_i, out_byte_o, ... | out
//  config  | cfg_we_i, cfg_idx_i, cfg_data_i           | in
//
//  An input byte is converted in the cycle it transfers; its result is
//  registered into the output register. A two-byte result leaves one byte
//  at a time through the byte-wide output register, which takes no new
//  input byte until its last byte leaves. A held lead byte yields nothing.
//  Reset clears config, lead hold and output valid. Output stall back-
//  pressures the input only while the output register cannot be refilled.
module sjis_half_full_width_converter_unit import sjis_hfw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  logic       dir_q, byp_q;
  logic       pend_q, pend_d;
  logic [7:0] lead_q;
  logic       emit;
  res_t       res;
  // output register: current byte plus an optional second queued byte
  logic       ov_q;
  logic       two_q;
  logic [7:0] b0_q, b1_q;
  logic       in_xfer, out_xfer, free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
      byp_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DIRECTION: dir_q <= cfg_data_i;
        CFG_BYPASS:    byp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sjis_hfw_convert u_conv (
    .direction_i (dir_q),
    .bypass_i    (byp_q),
    .pend_i      (pend_q),
    .lead_i      (lead_q),
    .byte_i      (in_byte_i),
    .eos_i       (end_of_string_i),
    .emit_o      (emit),
    .res_o       (res),
    .pend_o      (pend_d)
  );

  assign out_xfer   = ov_q && !out_stall_i;
  // register free when empty or once its last byte leaves
  assign free       = !ov_q || (out_xfer && !two_q);
  assign in_stall_o = !free;
  assign in_xfer    = in_valid_i && free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      lead_q <= 8'h00;
      ov_q   <= 1'b0;
      two_q  <= 1'b0;
    end else begin
      if (in_xfer) begin
        pend_q <= pend_d;
        lead_q <= in_byte_i;
      end
      if (in_xfer && emit) begin
        ov_q  <= 1'b1;
        two_q <= res.two;
      end else if (out_xfer) begin
        if (two_q) two_q <= 1'b0;
        else       ov_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && emit) begin
      b0_q <= res.b0;
      b1_q <= res.b1;
    end else if (out_xfer && two_q) begin
      b0_q <= b1_q;
    end
  end

  assign out_valid_o   = ov_q;
  assign out_byte_o    = b0_q;
  assign last_of_run_o = !two_q;

endmodule

// ----- rtl/core/sjis_hfw_to_half.sv -----
// ----------------------------------------------------------------------------
// SJIS full to half width lookup
// Parallel match of a two-byte code against both tables, first hit wins.
// ----------------------------------------------------------------------------
module sjis_hfw_to_half import sjis_hfw_pkg::*; (
  input  logic [15:0] code_i,
  output logic        hit_o,
  output logic [7:0]  half_o
);

  logic [94:0] lo_hit;
  logic [62:0] up_hit;

  always_comb begin
    for (int i = 0; i < 95; i++) lo_hit[i] = (lower_code(7'(i)) == code_i);
    for (int j = 0; j < 63; j++) up_hit[j] = (upper_code(6'(j)) == code_i);
  end

  // priority encode, lowest index first
  always_comb begin
    hit_o  = 1'b0;
    half_o = 8'h00;
    for (int j = 62; j >= 0; j--) begin
      if (up_hit[j]) begin
        hit_o  = 1'b1;
        half_o = UpFirst + 8'(j);
      end
    end
    for (int i = 94; i >= 0; i--) begin
      if (lo_hit[i]) begin
        hit_o  = 1'b1;
        half_o = LowFirst + 8'(i);
      end
    end
  end

endmodule

// ----- rtl/core/sjis_hfw_convert.sv -----
// ----------------------------------------------------------------------------
// SJIS converter core logic
// Decides the result for one input byte and the next lead-hold state.
// ----------------------------------------------------------------------------
module sjis_hfw_convert import sjis_hfw_pkg::*; (
  input  logic       direction_i,
  input  logic       bypass_i,
  input  logic       pend_i,
  input  logic [7:0] lead_i,
  input  logic [7:0] byte_i,
  input  logic       eos_i,
  output logic       emit_o,
  output res_t       res_o,
  output logic       pend_o
);

  logic        hit;
  logic [7:0]  half;
  logic [15:0] lcode;
  logic [15:0] ucode;
  logic [7:0]  lo_off;
  logic [7:0]  up_off;

  assign lo_off = byte_i - LowFirst;
  assign up_off = byte_i - UpFirst;
  assign lcode  = lower_code(lo_off[6:0]);
  assign ucode  = upper_code(up_off[5:0]);

  sjis_hfw_to_half u_half (
    .code_i ({lead_i, byte_i}),
    .hit_o  (hit),
    .half_o (half)
  );

  always_comb begin
    emit_o = 1'b1;
    pend_o = 1'b0;
    res_o  = '{two: 1'b0, b0: byte_i, b1: byte_i};
    if (pend_i) begin
      if (!bypass_i && direction_i && hit) begin
        res_o.b0 = half;
      end else begin
        res_o = '{two: 1'b1, b0: lead_i, b1: byte_i};
      end
    end else if (bypass_i) begin
      // single byte as is
    end else if (is_lead(byte_i)) begin
      if (!eos_i) begin
        emit_o = 1'b0;
        pend_o = 1'b1;
      end
    end else if (!direction_i) begin
      if (byte_i >= LowFirst && byte_i <= LowLast) begin
        res_o = '{two: 1'b1, b0: lcode[15:8], b1: lcode[7:0]};
      end else if (byte_i >= UpFirst && byte_i <= UpLast) begin
        res_o = '{two: 1'b1, b0: ucode[15:8], b1: ucode[7:0]};
      end
    end
  end

endmodule
